FILE: hw/rtl/utf8_stream_decoder_top_assert.svh
// assertion macros used by the utf8 stream decoder back end
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UTF8SD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/utf8sd_pkg.sv
// package with shared types, constants and helpers of the utf8 stream decoder
package utf8sd_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadEd = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;
  localparam logic [7:0] ContLo = 8'h80;
  localparam logic [7:0] ContHi = 8'hBF;
  localparam logic [7:0] ContLoE0 = 8'hA0;
  localparam logic [7:0] ContHiEd = 8'h9F;
  localparam logic [7:0] ContLoF0 = 8'h90;
  localparam logic [7:0] ContHiF4 = 8'h8F;
  localparam logic [7:0] AsciiLimit = 8'h80;

  // one word's worth of results: replacements first, then an optional tail
  typedef struct packed {
    logic [1:0]     rep_cnt;
    logic           has_tail;
    logic [CpW-1:0] tail_cp;
    logic           tail_err;
  } desc_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
    else if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
    else if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
    return len;
  endfunction

endpackage

FILE: hw/rtl/utf8sd_front.sv
// front end: accepts text words, tracks the open sequence, queues result descriptors
module utf8sd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output utf8sd_pkg::desc_t  desc_o
);

  logic [7:0]  lead_q, lead_d;
  logic [1:0]  count_q, count_d;
  logic [11:0] gath_q, gath_d;

  logic        accept;
  logic [2:0]  total;
  logic [2:0]  count_ext;
  logic [7:0]  lo, hi;
  logic        fits;
  logic [5:0]  payload;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_ext  = {1'b0, count_q};
  assign payload    = data_byte_i[5:0];

  always_comb begin
    total = utf8sd_pkg::seq_len(lead_q);
    lo = utf8sd_pkg::ContLo;
    hi = utf8sd_pkg::ContHi;
    if (count_q == 2'd1) begin
      if (lead_q == utf8sd_pkg::LeadE0) lo = utf8sd_pkg::ContLoE0;
      else if (lead_q == utf8sd_pkg::LeadEd) hi = utf8sd_pkg::ContHiEd;
      else if (lead_q == utf8sd_pkg::LeadF0) lo = utf8sd_pkg::ContLoF0;
      else if (lead_q == utf8sd_pkg::LeadF4) hi = utf8sd_pkg::ContHiF4;
    end
    fits = (count_q != 2'd0) && (data_byte_i != 8'd0) && (data_byte_i >= lo)
           && (data_byte_i <= hi) && (total > count_ext);
  end

  always_comb begin
    lead_d  = lead_q;
    count_d = count_q;
    gath_d  = gath_q;
    desc_o  = '0;
    if (fits) begin
      if (count_ext + 3'd1 == total) begin
        desc_o.has_tail = 1'b1;
        unique case (total)
          3'd2:    desc_o.tail_cp = {10'd0, lead_q[4:0], payload};
          3'd3:    desc_o.tail_cp = {5'd0, lead_q[3:0], gath_q[5:0], payload};
          default: desc_o.tail_cp = {lead_q[2:0], gath_q, payload};
        endcase
        lead_d  = '0;
        count_d = '0;
        gath_d  = '0;
      end else begin
        gath_d  = {gath_q[5:0], payload};
        count_d = count_q + 2'd1;
      end
    end else begin
      desc_o.rep_cnt = count_q;
      lead_d  = '0;
      count_d = '0;
      gath_d  = '0;
      if (data_byte_i == 8'd0) begin
        desc_o.has_tail = 1'b0;
      end else if (data_byte_i < utf8sd_pkg::AsciiLimit) begin
        desc_o.has_tail = 1'b1;
        desc_o.tail_cp  = {13'd0, data_byte_i};
      end else if (utf8sd_pkg::seq_len(data_byte_i) != 3'd0) begin
        lead_d  = data_byte_i;
        count_d = 2'd1;
      end else begin
        desc_o.has_tail = 1'b1;
        desc_o.tail_cp  = utf8sd_pkg::ReplChar;
        desc_o.tail_err = 1'b1;
      end
    end
  end

  assign push_o = accept && ((desc_o.rep_cnt != 2'd0) || desc_o.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      count_q <= '0;
      gath_q  <= '0;
    end else if (accept) begin
      lead_q  <= lead_d;
      count_q <= count_d;
      gath_q  <= gath_d;
    end
  end

endmodule

FILE: hw/rtl/utf8sd_fifo.sv
// short descriptor queue between front and back
module utf8sd_fifo #(
  parameter int unsigned Depth = utf8sd_pkg::FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  utf8sd_pkg::desc_t  wdata_i,
  input  logic               pop_i,
  output utf8sd_pkg::desc_t  rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  utf8sd_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (pop_i) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: hw/rtl/utf8sd_back.sv
// back end: expands descriptors into result words behind an output register
`include "utf8_stream_decoder_top_assert.svh"

module utf8sd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  utf8sd_pkg::desc_t         head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [utf8sd_pkg::CpW-1:0] code_point_o,
  output logic                      is_error_o,
  output logic                      last_of_run_o
);

  utf8sd_pkg::desc_t cur_q, cur_d;
  logic cur_valid_q, cur_valid_d;
  logic out_valid_q;
  logic [utf8sd_pkg::CpW-1:0] cp_q;
  logic err_q, last_q;

  logic advance, emit, cur_done;
  logic [utf8sd_pkg::CpW-1:0] res_cp;
  logic res_err, res_last;

  assign advance = !out_valid_q || out_ready_i;
  assign emit    = advance && cur_valid_q;

  always_comb begin
    if (cur_q.rep_cnt != 2'd0) begin
      res_cp   = utf8sd_pkg::ReplChar;
      res_err  = 1'b1;
      res_last = (cur_q.rep_cnt == 2'd1) && !cur_q.has_tail;
    end else begin
      res_cp   = cur_q.tail_cp;
      res_err  = cur_q.tail_err;
      res_last = 1'b1;
    end
  end

  assign cur_done = emit && res_last;
  assign pop_o    = !empty_i && (!cur_valid_q || cur_done);

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    if (pop_o) begin
      cur_d       = head_i;
      cur_valid_d = 1'b1;
    end else if (cur_done) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      cur_d.rep_cnt = cur_q.rep_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      if (advance) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      cp_q   <= res_cp;
      err_q  <= res_err;
      last_q <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign is_error_o    = err_q;
  assign last_of_run_o = last_q;

  `UTF8SD_ASSERT_IMPL(a_err_is_repl, clk_i, rst_ni, out_valid_q && err_q,
    cp_q == utf8sd_pkg::ReplChar, "error word without replacement char")
  `UTF8SD_ASSERT_IMPL(a_scalar_ok, clk_i, rst_ni, out_valid_q && !err_q,
    (cp_q <= utf8sd_pkg::MaxScalar) && ((cp_q < utf8sd_pkg::SurrLo) ||
    (cp_q > utf8sd_pkg::SurrHi)), "content word is not a scalar value")
  `UTF8SD_ASSERT_IMPL(a_cur_nonempty, clk_i, rst_ni,
    cur_valid_q && (cur_q.rep_cnt == 2'd0), cur_q.has_tail,
    "working descriptor holds no result")
  `UTF8SD_ASSERT_NEXT(a_done_emits_last, clk_i, rst_ni, cur_done,
    out_valid_q && last_q, "finished descriptor without last word")

endmodule

FILE: hw/rtl/utf8_stream_decoder_top.sv
// top level of the utf8 stream decoder
//
// input channel: in_valid_i / in_ready_o carry one text byte per word on
// data_byte_i; a zero byte ends the text and flushes an open sequence.
// output channel: out_valid_o / out_ready_i carry one result word with
// code_point_o, is_error_o and last_of_run_o; last_of_run_o marks the final
// word caused by one input byte, and bytes that cause nothing give no word.
// a result passes through the queue write, then the descriptor load, then
// the output register.
// throughput: one byte per cycle while each byte yields at most one word and
// out_ready_i stays high; the n words of one byte (up to 4) go out in turn.
// the front keeps taking bytes until the descriptor queue of FifoDepth
// entries fills, then in_ready_o drops until the back drains an entry.
// a receiver stall holds the output word and backs up into the queue.
// reset clears the open sequence, empties the queue and drops out_valid_o.
module utf8_stream_decoder_top #(
  parameter int unsigned FifoDepth = utf8sd_pkg::FifoDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [utf8sd_pkg::CpW-1:0] code_point_o,
  output logic                       is_error_o,
  output logic                       last_of_run_o
);

  utf8sd_pkg::desc_t push_desc, head_desc;
  logic push, pop, full, empty;

  utf8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .fifo_full_i (full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  utf8sd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .full_o  (full),
    .empty_o (empty)
  );

  utf8sd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .is_error_o    (is_error_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the utf8 stream decoder top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8sd_pkg::*;

  localparam logic [7:0] EndOfText = 8'h00;
  localparam int unsigned MaxWait = 18;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
    logic           last;
  } scalar_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     data_byte = 8'h00;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CpW-1:0] code_point;
  logic           is_error;
  logic           last_of_run;

  // decoder state as seen by the predictor
  logic [7:0]     open_lead;
  logic [1:0]     open_count;
  logic [11:0]    open_bits;

  scalar_t        decoded_chars[$];
  bit             steady = 1'b0;
  int unsigned    error_count = 0;
  int unsigned    text_bytes = 0;
  int unsigned    chars_checked = 0;
  int unsigned    repl_checked = 0;

  utf8_stream_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_point_o  (code_point),
    .is_error_o    (is_error),
    .last_of_run_o (last_of_run)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned lead_len(input logic [7:0] b);
    if (b >= Lead2Lo && b <= Lead2Hi) return 2;
    if (b >= Lead3Lo && b <= Lead3Hi) return 3;
    if (b >= Lead4Lo && b <= Lead4Hi) return 4;
    return 0;
  endfunction

  function automatic void clear_open();
    open_lead = 8'h00;
    open_count = 2'd0;
    open_bits = 12'h000;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [CpW-1:0] cps[4];
    logic           errs[4];
    int unsigned    n;
    int unsigned    total;
    logic [7:0]     lo;
    logic [7:0]     hi;
    bit             fits;
    scalar_t        s;
    n = 0;
    fits = 1'b0;
    if (open_count != 2'd0) begin
      total = lead_len(open_lead);
      lo = ContLo;
      hi = ContHi;
      if (open_count == 2'd1) begin
        case (open_lead)
          LeadE0: lo = ContLoE0;
          LeadEd: hi = ContHiEd;
          LeadF0: lo = ContLoF0;
          LeadF4: hi = ContHiF4;
          default: ;
        endcase
      end
      if (b != EndOfText && b >= lo && b <= hi && total > open_count) begin
        fits = 1'b1;
        if (open_count + 1 == total) begin
          case (total)
            2: cps[0] = CpW'({open_lead[4:0], b[5:0]});
            3: cps[0] = CpW'({open_lead[3:0], open_bits[5:0], b[5:0]});
            default: cps[0] = {open_lead[2:0], open_bits, b[5:0]};
          endcase
          errs[0] = 1'b0;
          n = 1;
          clear_open();
        end else begin
          open_bits = {open_bits[5:0], b[5:0]};
          open_count = open_count + 2'd1;
        end
      end else begin
        for (int unsigned k = 0; k < open_count; k++) begin
          cps[n] = ReplChar;
          errs[n] = 1'b1;
          n++;
        end
        clear_open();
      end
    end
    if (!fits) begin
      if (b == EndOfText) begin
      end else if (b < AsciiLimit) begin
        cps[n] = CpW'(b);
        errs[n] = 1'b0;
        n++;
      end else if (lead_len(b) != 0) begin
        open_lead = b;
        open_count = 2'd1;
        open_bits = 12'h000;
      end else begin
        cps[n] = ReplChar;
        errs[n] = 1'b1;
        n++;
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      s.cp = cps[i];
      s.err = errs[i];
      s.last = (i == n - 1);
      decoded_chars.push_back(s);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    decode_byte(b);
    if (b != EndOfText) text_bytes++;
  endtask

  function automatic int unsigned encode_scalar(input logic [CpW-1:0] cp,
                                                output logic [3:0][7:0] seq);
    seq = '0;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      return 3;
    end
    seq[0] = {5'b11110, cp[20:18]};
    seq[1] = {2'b10, cp[17:12]};
    seq[2] = {2'b10, cp[11:6]};
    seq[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  task automatic send_scalar(input logic [CpW-1:0] cp);
    logic [3:0][7:0] seq;
    int unsigned     n;
    n = encode_scalar(cp, seq);
    for (int unsigned i = 0; i < n; i++) send_byte(seq[i]);
  endtask

  function automatic logic [CpW-1:0] random_scalar();
    logic [CpW-1:0] cp;
    case ($urandom_range(0, 3))
      0: cp = CpW'($urandom_range(1, 'h7F));
      1: cp = CpW'($urandom_range('h80, 'h7FF));
      2: begin
        cp = CpW'($urandom_range('h800, 'hFFFF));
        if (cp >= SurrLo && cp <= SurrHi) cp = cp - 21'h800;
      end
      default: cp = CpW'($urandom_range('h10000, MaxScalar));
    endcase
    return cp;
  endfunction

  task automatic test_plain_text();
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(EndOfText);
  endtask

  task automatic test_sequence_bounds();
    send_scalar(21'h000080);
    send_scalar(21'h000800);
    send_scalar(21'h00D7FF);
    send_scalar(ReplChar);
    send_scalar(21'h010000);
    send_scalar(MaxScalar);
  endtask

  task automatic test_replacement();
    send_byte(8'hC1);
    send_byte(8'hF5);
    send_byte(LeadF0);
    send_byte(ContLoF0);
    send_byte(EndOfText);
    send_byte(LeadE0);
    send_byte(ContLo);
  endtask

  task automatic test_random_text(input int unsigned count);
    logic [3:0][7:0] seq;
    logic [CpW-1:0]  cp;
    int unsigned     n;
    int unsigned     stop_at;
    int unsigned     pick;
    stop_at = text_bytes + count;
    while (text_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_scalar(random_scalar());
      end else if (pick < 72) begin
        send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 82) begin
        // truncated sequence, the next word interrupts it
        do begin
          cp = random_scalar();
          n = encode_scalar(cp, seq);
        end while (n < 2);
        n = $urandom_range(1, n - 1);
        for (int unsigned i = 0; i < n; i++) send_byte(seq[i]);
      end else if (pick < 92) begin
        // second byte just outside the allowed range
        case ($urandom_range(0, 3))
          0: begin send_byte(LeadE0); send_byte(8'($urandom_range('h80, 'h9F))); end
          1: begin send_byte(LeadEd); send_byte(8'($urandom_range('hA0, 'hBF))); end
          2: begin send_byte(LeadF0); send_byte(8'($urandom_range('h80, 'h8F))); end
          default: begin send_byte(LeadF4); send_byte(8'($urandom_range('h90, 'hBF))); end
        endcase
      end else if (pick < 96) begin
        send_byte(EndOfText);
      end else begin
        case ($urandom_range(0, 5))
          0: send_scalar(21'h0007FF);
          1: send_scalar(21'h00FFFF);
          2: send_scalar(21'h00E000);
          3: send_scalar(MaxScalar);
          4: send_scalar(21'h010000);
          default: send_scalar(21'h00007F);
        endcase
      end
    end
  endtask

  // receiver with random stalls, checks every word it takes
  initial begin
    int unsigned stall;
    scalar_t     want;
    forever begin
      stall = steady ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(negedge clk_i); while (!(out_valid && rst_ni));
      if (decoded_chars.size() == 0) begin
        $display("%0t: unexpected word cp %h err %b last %b", $time,
                 code_point, is_error, last_of_run);
        error_count++;
      end else begin
        want = decoded_chars.pop_front();
        chars_checked++;
        if (want.err) repl_checked++;
        if (code_point !== want.cp) begin
          $display("%0t: code_point expected %h actual %h", $time, want.cp, code_point);
          error_count++;
        end
        if (is_error !== want.err) begin
          $display("%0t: is_error expected %b actual %b", $time, want.err, is_error);
          error_count++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                   last_of_run);
          error_count++;
        end
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    clear_open();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_text();
    test_sequence_bounds();
    test_replacement();
    test_random_text(200);
    steady = 1'b1;
    test_random_text(100);
    steady = 1'b0;
    test_random_text(150);
    in_valid <= 1'b0;
    while (decoded_chars.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_chars.size() != 0) begin
      $display("%0t: %0d words never arrived", $time, decoded_chars.size());
      error_count++;
    end
    $display("fed %0d text bytes, checked %0d code points (%0d replacements)",
             text_bytes, chars_checked, repl_checked);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
